// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the allocator control module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FFA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FFA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and status codes of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   // Request transaction.
   typedef struct packed {
      logic        mode;
      logic [15:0] request_size;
      logic [15:0] payload_offset;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [15:0] address;
      logic [2:0]  status;
   } rsp_type;

   // One entry of the block table.
   typedef struct packed {
      logic [15:0] offset;
      logic [15:0] size;
      logic        free;
   } entry_type;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_OOM       = 3'd1;
   localparam logic [2:0] ST_FREED     = 3'd2;
   localparam logic [2:0] ST_NULL      = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;

   localparam logic [16:0] ALIGN_UNIT = 17'd16;
   localparam logic [16:0] ALIGN_MASK = 17'd15;

endpackage

// File: design/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Block table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ffa_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output ffa_pkg::entry_type  rd_data
);
   import ffa_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port: the entry appears in the cycle after its address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer that scans, splits and merges the block table in memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_ctrl #(
   parameter int ARENA_BYTES  = 65536,
   parameter int HEADER_BYTES = 24,
   parameter int MAX_BLOCKS   = 2048,
   parameter int AW           = 11,
   parameter int CW           = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ffa_pkg::req_type    req_payload,
   output logic                res_valid,
   input  logic                res_take,
   output ffa_pkg::rsp_type    res_payload,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output ffa_pkg::entry_type  wr_data,
   output logic [AW-1:0]       rd_addr,
   input  ffa_pkg::entry_type  rd_data
);
   import ffa_pkg::*;

   localparam logic [16:0]   HDR      = 17'(HEADER_BYTES);
   localparam logic [16:0]   SPLIT_TH = 17'(HEADER_BYTES + 16);
   localparam logic [15:0]   INIT_SZ  = 16'(ARENA_BYTES - HEADER_BYTES);
   localparam logic [CW-1:0] MAXC     = CW'(MAX_BLOCKS);

   typedef enum logic [7:0] {
      S_INIT  = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SCAN  = 8'b0000_0100,
      S_SHIFT = 8'b0000_1000,
      S_SPLIT = 8'b0001_0000,
      S_TAKE  = 8'b0010_0000,
      S_MERGE = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic          mode_ff, mode_in;
   logic [16:0]   need_ff, need_in;
   logic [15:0]   payload_ff, payload_in;
   logic [AW-1:0] hit_ff, hit_in;
   entry_type     hit_entry_ff, hit_entry_in;
   logic [15:0]   rest_ff, rest_in;
   logic          split_ff, split_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   entry_type     pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   rsp_type       res_ff, res_in;

   logic [16:0]   req_round;
   logic [16:0]   rest_full;
   logic          match;
   logic          more;
   logic [CW-1:0] hit_next;
   entry_type     cur;

   // Request size raised to the alignment unit and rounded up.
   always_comb begin
      req_round = (req_payload.request_size == 16'd0) ? ALIGN_UNIT
                : ({1'b0, req_payload.request_size} + ALIGN_MASK) & ~ALIGN_MASK;
   end

   // Comparisons on the entry that has just been read.
   always_comb begin
      rest_full = {1'b0, rd_data.size} - need_ff;
      if (mode_ff == MODE_ALLOC) begin
         match = rd_data.free && ({1'b0, rd_data.size} >= need_ff);
      end else begin
         match = ({1'b0, rd_data.offset} + HDR) == {1'b0, payload_ff};
      end
      more     = idx_ff < count_ff;
      hit_next = CW'(hit_ff) + CW'(1);
      cur      = rd_data;
      if (chk_idx_ff == hit_ff) begin
         cur.free = 1'b1;
      end
   end

   // Read address: the shift walks downwards and reads the entry below.
   always_comb begin
      if (state_ff == S_SHIFT) begin
         rd_addr = AW'(idx_ff - CW'(1));
      end else begin
         rd_addr = AW'(idx_ff);
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      mode_in       = mode_ff;
      need_in       = need_ff;
      payload_in    = payload_ff;
      hit_in        = hit_ff;
      hit_entry_in  = hit_entry_ff;
      rest_in       = rest_ff;
      split_in      = split_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = pend_ff;

      case (state_ff)
         S_INIT: begin
            // One free block covering the arena.
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data.offset = 16'd0;
            wr_data.size   = INIT_SZ;
            wr_data.free   = 1'b1;
            count_in       = CW'(1);
            state_in       = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in    = req_payload.mode;
               need_in    = req_round;
               payload_in = req_payload.payload_offset;
               idx_in     = '0;
               if (req_payload.mode == MODE_FREE && req_payload.payload_offset == 16'd0) begin
                  res_in.address = 16'd0;
                  res_in.status  = ST_NULL;
                  state_in       = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (more) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = AW'(idx_ff);
               idx_in       = idx_ff + CW'(1);
            end
            if (chk_valid_ff && match) begin
               chk_valid_in = 1'b0;
               hit_in       = chk_idx_ff;
               hit_entry_in = rd_data;
               rest_in      = rest_full[15:0];
               split_in     = (rest_full > SPLIT_TH) && (count_ff < MAXC);
               if (mode_ff == MODE_ALLOC) begin
                  if ((rest_full > SPLIT_TH) && (count_ff < MAXC)) begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_TAKE;
                  end
               end else begin
                  idx_in        = '0;
                  wr_idx_in     = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_MERGE;
               end
            end else if (!chk_valid_ff && !more) begin
               res_in.address = 16'd0;
               res_in.status  = (mode_ff == MODE_ALLOC) ? ST_OOM : ST_UNKNOWN;
               state_in       = S_DONE;
            end
         end
         S_SHIFT: begin
            // Move entries above the hit up by one, top first.
            if (idx_ff > hit_next) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = AW'(idx_ff);
               idx_in       = idx_ff - CW'(1);
            end
            if (chk_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff;
               wr_data = rd_data;
            end
            if (!chk_valid_ff && idx_ff <= hit_next) begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            // Remainder becomes a new free block just above the hit.
            wr_en          = 1'b1;
            wr_addr        = AW'(hit_next);
            wr_data.offset = 16'({1'b0, hit_entry_ff.offset} + HDR + need_ff);
            wr_data.size   = 16'({1'b0, rest_ff} - HDR);
            wr_data.free   = 1'b1;
            count_in       = count_ff + CW'(1);
            state_in       = S_TAKE;
         end
         S_TAKE: begin
            wr_en          = 1'b1;
            wr_addr        = hit_ff;
            wr_data.offset = hit_entry_ff.offset;
            wr_data.size   = split_ff ? need_ff[15:0] : hit_entry_ff.size;
            wr_data.free   = 1'b0;
            res_in.address = 16'({1'b0, hit_entry_ff.offset} + HDR);
            res_in.status  = ST_ALLOCATED;
            state_in       = S_DONE;
         end
         S_MERGE: begin
            // Compact the table, folding each free run into its first block.
            if (more) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = AW'(idx_ff);
               idx_in       = idx_ff + CW'(1);
            end
            if (chk_valid_ff) begin
               if (pend_valid_ff && pend_ff.free && cur.free) begin
                  pend_in.size = 16'({1'b0, pend_ff.size} + HDR + {1'b0, cur.size});
               end else begin
                  if (pend_valid_ff) begin
                     wr_en     = 1'b1;
                     wr_addr   = wr_idx_ff;
                     wr_idx_in = wr_idx_ff + AW'(1);
                  end
                  pend_in       = cur;
                  pend_valid_in = 1'b1;
               end
            end else if (!more) begin
               wr_en          = 1'b1;
               wr_addr        = wr_idx_ff;
               count_in       = CW'(wr_idx_ff) + CW'(1);
               res_in.address = 16'd0;
               res_in.status  = ST_FREED;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= CW'(1);
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_valid_ff  <= chk_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
      mode_ff      <= mode_in;
      need_ff      <= need_in;
      payload_ff   <= payload_in;
      hit_ff       <= hit_in;
      hit_entry_ff <= hit_entry_in;
      rest_ff      <= rest_in;
      split_ff     <= split_in;
      wr_idx_ff    <= wr_idx_in;
      pend_ff      <= pend_in;
      res_ff       <= res_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign res_valid   = (state_ff == S_DONE);
   assign res_payload = res_ff;

   `FFA_ASSERT_ALWAYS(a_reset_init, clock, reset |=> state_ff == S_INIT, "no init after reset")
   `FFA_ASSERT(a_count_range, clock, reset,
      state_ff != S_INIT |-> (count_ff != '0 && count_ff <= MAXC), "block count out of range")
   `FFA_ASSERT(a_idle_no_write, clock, reset,
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr_en, "table written while idle")
   `FFA_ASSERT(a_shift_above_hit, clock, reset,
      (state_ff == S_SHIFT && wr_en) |-> wr_addr > hit_ff, "shift overwrote the hit entry")

endmodule

// File: design/first_fit_arena_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit allocator over an address-ordered block table held in memory.
// ----------------------------------------------------------------------------
// Usage:
//  A request transaction on req_ (valid/stall) carries mode, request_size and
//  payload_offset; every request yields exactly one response transaction on
//  rsp_ carrying address and status, in order.
//  One request is worked on at a time; req_stall is low only while the
//  sequencer is idle. An allocate scans the table from entry 0 to the first
//  fitting free block and then claims it; when the block is split, the
//  entries above it first shift up one a cycle and the remainder is written
//  as a new free block. A free scans for the block and then makes a merge
//  pass over the whole table; a null free answers without a scan.
//  The table memory has a single read port, which returns one entry a cycle.
//  After reset the block writes the initial free block before it takes
//  requests. The response sits in an output register; a stalled response
//  holds, and the next request is still accepted, its own response waiting
//  in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator #(
   parameter int ARENA_BYTES  = 65536,
   parameter int HEADER_BYTES = 24,
   parameter int MAX_BLOCKS   = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffa_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffa_pkg::rsp_type  rsp_payload
);
   import ffa_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   logic          res_valid;
   logic          res_take;
   rsp_type       res_payload;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   ffa_ctrl #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .AW           (AW),
      .CW           (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_payload (res_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   ffa_ram #(
      .DEPTH (MAX_BLOCKS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: loads when empty or when its transaction completes.
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
